// ----- rtl/rrp_pkg.sv -----
`timescale 1ns / 1ps
// rrp_pkg: types, codes and byte constants of the row record parser.
// No dependencies.

package rrp_pkg;

   localparam logic [2:0] KIND_NAME_BYTE   = 3'd0;
   localparam logic [2:0] KIND_VALUE_BYTE  = 3'd1;
   localparam logic [2:0] KIND_EMPTY_NAME  = 3'd2;
   localparam logic [2:0] KIND_EMPTY_VALUE = 3'd3;
   localparam logic [2:0] KIND_STATUS      = 3'd4;

   localparam logic [3:0] ST_OK         = 4'd0;
   localparam logic [3:0] ST_PREFIX     = 4'd1;
   localparam logic [3:0] ST_COUNT      = 4'd2;
   localparam logic [3:0] ST_HEADER     = 4'd3;
   localparam logic [3:0] ST_NAMELEN    = 4'd4;
   localparam logic [3:0] ST_NAMESEP    = 4'd5;
   localparam logic [3:0] ST_NAMERANGE  = 4'd6;
   localparam logic [3:0] ST_VALLEN     = 4'd7;
   localparam logic [3:0] ST_VALSEP     = 4'd8;
   localparam logic [3:0] ST_VALRANGE   = 4'd9;
   localparam logic [3:0] ST_EXTRA      = 4'd10;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] column_index;
      logic [7:0]  data_byte;
      logic        field_end;
      logic [3:0]  status_code;
      logic [15:0] column_count;
   } rrp_result_type;

   function automatic logic [7:0] row_tag(input logic [1:0] idx);
      logic [7:0] ch;
      unique case (idx)
         2'd0: ch = 8'h52;
         2'd1: ch = 8'h4F;
         2'd2: ch = 8'h57;
         default: ch = CHAR_SPACE;
      endcase
      return ch;
   endfunction

endpackage

// ----- rtl/rrp_channels.sv -----
`timescale 1ns / 1ps
// rrp_req_if / rrp_rsp_if: valid/ready channels of the row record parser.
// Depends on rrp_pkg for the result codes only by convention.

interface rrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface rrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [15:0] column_index;
   logic [7:0]  data_byte;
   logic        field_end;
   logic [3:0]  status_code;
   logic [15:0] column_count;

   modport source (output valid, output kind, output column_index, output data_byte,
                   output field_end, output status_code, output column_count,
                   input ready);
   modport sink   (input valid, input kind, input column_index, input data_byte,
                   input field_end, input status_code, input column_count,
                   output ready);
endinterface

// ----- rtl/rrp_parse_core.sv -----
`timescale 1ns / 1ps
// rrp_parse_core: line state registers and the per-word parse logic.
// Depends on rrp_pkg.

module rrp_parse_core
   import rrp_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_accept,
   input  logic [7:0]     in_byte,
   output logic           result_valid,
   output rrp_result_type result
);

   localparam logic [2:0] PH_PREFIX  = 3'd0;
   localparam logic [2:0] PH_COUNT   = 3'd1;
   localparam logic [2:0] PH_NAMELEN = 3'd2;
   localparam logic [2:0] PH_NAME    = 3'd3;
   localparam logic [2:0] PH_VALLEN  = 3'd4;
   localparam logic [2:0] PH_VALUE   = 3'd5;
   localparam logic [2:0] PH_END     = 3'd6;
   localparam logic [2:0] PH_SKIP    = 3'd7;

   localparam int WIDE_BITS = COUNT_BITS + 4;

   logic [2:0]            phase_ff, phase_in;
   logic [1:0]            prefix_ff, prefix_in;
   logic [COUNT_BITS-1:0] acc_ff, acc_in;
   logic                  minus_ff, minus_in;
   logic                  digit_ff, digit_in;
   logic [COUNT_BITS-1:0] cols_ff, cols_in;
   logic [COUNT_BITS-1:0] col_ff, col_in;
   logic [COUNT_BITS-1:0] left_ff, left_in;
   logic [3:0]            error_ff, error_in;

   logic                  is_newline;
   logic                  is_digit;
   logic                  take_minus;
   logic                  num_ok;
   logic [WIDE_BITS-1:0]  acc_wide;
   logic [COUNT_BITS-1:0] acc_sat;
   logic [COUNT_BITS-1:0] col_inc;
   logic                  is_name;
   logic [31:0]           col_wide;
   logic [31:0]           cols_wide;

   assign is_newline = (in_byte == CHAR_NEWLINE);
   assign is_digit   = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
   assign take_minus = (in_byte == CHAR_MINUS) && !minus_ff && !digit_ff;
   assign num_ok     = digit_ff && !(minus_ff && (acc_ff != '0));
   assign acc_wide   = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                     + WIDE_BITS'(in_byte[3:0]);
   assign acc_sat    = (|acc_wide[WIDE_BITS-1:COUNT_BITS]) ? '1 : acc_wide[COUNT_BITS-1:0];
   assign col_inc    = col_ff + COUNT_BITS'(1);
   assign is_name    = (phase_ff == PH_NAMELEN) || (phase_ff == PH_NAME);
   assign col_wide   = 32'(col_ff);

   always_comb begin
      phase_in     = phase_ff;
      prefix_in    = prefix_ff;
      acc_in       = acc_ff;
      minus_in     = minus_ff;
      digit_in     = digit_ff;
      cols_in      = cols_ff;
      col_in       = col_ff;
      left_in      = left_ff;
      error_in     = error_ff;
      result_valid = 1'b0;
      result       = '0;

      unique case (phase_ff)
         PH_PREFIX: begin
            if (in_byte != row_tag(prefix_ff)) begin
               error_in = ST_PREFIX;
               phase_in = PH_SKIP;
            end else if (prefix_ff == 2'd3) begin
               prefix_in = 2'd0;
               phase_in  = PH_COUNT;
               acc_in    = '0;
               minus_in  = 1'b0;
               digit_in  = 1'b0;
            end else begin
               prefix_in = prefix_ff + 2'd1;
            end
         end
         PH_COUNT: begin
            if (take_minus) begin
               minus_in = 1'b1;
            end else if (is_digit) begin
               acc_in   = acc_sat;
               digit_in = 1'b1;
            end else if (!num_ok) begin
               error_in = ST_COUNT;
               phase_in = PH_SKIP;
            end else begin
               cols_in = acc_ff;
               if (in_byte != CHAR_SPACE) begin
                  error_in = ST_HEADER;
                  phase_in = PH_SKIP;
               end else begin
                  col_in = '0;
                  if (acc_ff == '0) begin
                     phase_in = PH_END;
                  end else begin
                     phase_in = PH_NAMELEN;
                     acc_in   = '0;
                     minus_in = 1'b0;
                     digit_in = 1'b0;
                  end
               end
            end
         end
         PH_NAMELEN, PH_VALLEN: begin
            if (take_minus) begin
               minus_in = 1'b1;
            end else if (is_digit) begin
               acc_in   = acc_sat;
               digit_in = 1'b1;
            end else if (!num_ok) begin
               error_in = is_name ? ST_NAMELEN : ST_VALLEN;
               phase_in = PH_SKIP;
            end else if (in_byte != CHAR_COLON) begin
               error_in = is_name ? ST_NAMESEP : ST_VALSEP;
               phase_in = PH_SKIP;
            end else begin
               left_in = acc_ff;
               if (acc_ff != '0) begin
                  phase_in = is_name ? PH_NAME : PH_VALUE;
               end else begin
                  result_valid        = 1'b1;
                  result.kind         = is_name ? KIND_EMPTY_NAME : KIND_EMPTY_VALUE;
                  result.column_index = col_wide[15:0];
                  acc_in   = '0;
                  minus_in = 1'b0;
                  digit_in = 1'b0;
                  if (is_name) begin
                     phase_in = PH_VALLEN;
                  end else begin
                     col_in   = col_inc;
                     phase_in = (col_inc >= cols_ff) ? PH_END : PH_NAMELEN;
                  end
               end
            end
         end
         PH_NAME, PH_VALUE: begin
            if (is_newline) begin
               error_in = is_name ? ST_NAMERANGE : ST_VALRANGE;
               phase_in = PH_SKIP;
            end else begin
               left_in             = left_ff - COUNT_BITS'(1);
               result_valid        = 1'b1;
               result.kind         = is_name ? KIND_NAME_BYTE : KIND_VALUE_BYTE;
               result.column_index = col_wide[15:0];
               result.data_byte    = in_byte;
               result.field_end    = (left_ff == COUNT_BITS'(1));
               if (left_ff == COUNT_BITS'(1)) begin
                  acc_in   = '0;
                  minus_in = 1'b0;
                  digit_in = 1'b0;
                  if (is_name) begin
                     phase_in = PH_VALLEN;
                  end else begin
                     col_in   = col_inc;
                     phase_in = (col_inc >= cols_ff) ? PH_END : PH_NAMELEN;
                  end
               end
            end
         end
         PH_END: begin
            if (!is_newline) begin
               error_in = ST_EXTRA;
               phase_in = PH_SKIP;
            end
         end
         default: begin
         end
      endcase

      // report the line status, then return the line state to its start
      if (is_newline) begin
         result_valid        = 1'b1;
         result              = '0;
         result.kind         = KIND_STATUS;
         result.status_code  = error_in;
         result.column_count = cols_wide[15:0];
         phase_in  = PH_PREFIX;
         prefix_in = 2'd0;
         acc_in    = '0;
         minus_in  = 1'b0;
         digit_in  = 1'b0;
         cols_in   = '0;
         col_in    = '0;
         left_in   = '0;
         error_in  = ST_OK;
      end
   end

   // column count as it stands after this word, before the newline clear
   always_comb begin
      cols_wide = 32'(cols_ff);
      if ((phase_ff == PH_COUNT) && !take_minus && !is_digit && num_ok) begin
         cols_wide = 32'(acc_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_PREFIX;
         prefix_ff <= 2'd0;
         acc_ff    <= '0;
         minus_ff  <= 1'b0;
         digit_ff  <= 1'b0;
         cols_ff   <= '0;
         col_ff    <= '0;
         left_ff   <= '0;
         error_ff  <= ST_OK;
      end else if (in_accept) begin
         phase_ff  <= phase_in;
         prefix_ff <= prefix_in;
         acc_ff    <= acc_in;
         minus_ff  <= minus_in;
         digit_ff  <= digit_in;
         cols_ff   <= cols_in;
         col_ff    <= col_in;
         left_ff   <= left_in;
         error_ff  <= error_in;
      end
   end

   a_newline_status: assert property (@(posedge clock) disable iff (reset)
      in_accept && is_newline |-> result_valid && (result.kind == KIND_STATUS))
      else $error("newline word did not yield a line status");

   a_newline_clears: assert property (@(posedge clock) disable iff (reset)
      in_accept && is_newline |=> (phase_ff == PH_PREFIX) && (error_ff == ST_OK))
      else $error("line state not cleared after newline");

   a_skip_has_error: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP) == (error_ff != ST_OK))
      else $error("error latch and skip phase disagree");

   a_column_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_NAMELEN || phase_ff == PH_NAME || phase_ff == PH_VALLEN ||
       phase_ff == PH_VALUE) |-> (col_ff < cols_ff))
      else $error("current column beyond declared count");

endmodule

// ----- rtl/rrp_out_reg.sv -----
`timescale 1ns / 1ps
// rrp_out_reg: result register between the parse core and the result channel.
// Depends on rrp_pkg.

module rrp_out_reg
   import rrp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  logic           load_valid,
   input  rrp_result_type load_result,
   output logic           load_ready,
   output logic           out_valid,
   input  logic           out_ready,
   output rrp_result_type out_result
);

   logic           valid_ff, valid_in;
   rrp_result_type result_ff;

   assign load_ready = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      valid_in = valid_ff && !out_ready;
      if (load && load_valid) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && load_valid) begin
         result_ff <= load_result;
      end
   end

endmodule

// ----- rtl/row_record_parser.sv -----
`timescale 1ns / 1ps
// row_record_parser: top level, joins the parse core and the result register.
// Depends on rrp_pkg, rrp_channels, rrp_parse_core and rrp_out_reg.
//
// Takes stream bytes and gives at most one result word per byte, valid in the
// cycle after the byte is accepted. The byte is parsed in the cycle it is
// accepted against the line state registers; the result lands in a single
// output register. A byte is accepted whenever that register is empty or is
// being taken in the same cycle, so the sustained rate is one byte per cycle
// while the result side keeps up. No clearing pass after reset.

module row_record_parser
   import rrp_pkg::*;
#(
   parameter int COUNT_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   rrp_req_if.sink      req_chan,
   rrp_rsp_if.source    rsp_chan
);

   logic           accept;
   logic           load_ready;
   logic           core_valid;
   rrp_result_type core_result;
   rrp_result_type out_result;

   assign req_chan.ready = load_ready;
   assign accept         = req_chan.valid && load_ready;

   rrp_parse_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .in_accept    (accept),
      .in_byte      (req_chan.stream_byte),
      .result_valid (core_valid),
      .result       (core_result)
   );

   rrp_out_reg u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .load_valid  (core_valid),
      .load_result (core_result),
      .load_ready  (load_ready),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .out_result  (out_result)
   );

   assign rsp_chan.kind         = out_result.kind;
   assign rsp_chan.column_index = out_result.column_index;
   assign rsp_chan.data_byte    = out_result.data_byte;
   assign rsp_chan.field_end    = out_result.field_end;
   assign rsp_chan.status_code  = out_result.status_code;
   assign rsp_chan.column_count = out_result.column_count;

endmodule
